// File: sv/nrcd_pkg.sv
// Shared types and constants for the nibble run-length cel decoder.
package nrcd_pkg;

  // Configuration port geometry
  localparam int CFG_W = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CEL_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEL_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT = 2'd2;

  localparam logic [8:0] RESET_CEL_WIDTH   = 9'd16;
  localparam logic [8:0] RESET_CEL_HEIGHT  = 9'd16;
  localparam logic [3:0] RESET_TRANSPARENT = 4'd3;

  // Rows are padded up to a multiple of four pixels
  localparam int PAD_MASK = 3;

  // Input request
  typedef struct packed {
    logic [7:0] code_byte;
  } code_t;

  // Output request
  typedef struct packed {
    logic [3:0] pixel_color;
    logic [7:0] pixel_column;
    logic [7:0] pixel_row;
    logic       is_padding;
    logic       last_of_item;
    logic       image_done;
  } pixel_t;

  // One queued run
  typedef struct packed {
    logic [3:0] count;
    logic [3:0] color;
  } run_ent_t;

  // Queue head as seen by the expander
  typedef struct packed {
    logic     valid;
    run_ent_t ent;
  } run_head_t;

  // Geometry and restart control toward the expander
  typedef struct packed {
    logic       restart;
    logic [8:0] width;
    logic [8:0] height;
    logic [3:0] transparent;
  } geom_t;

endpackage

// File: sv/nrcd_chan_if.sv
// Valid/ready channel carrying one request of type T.
interface nrcd_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/nrcd_front.sv
// Front end: accepts code bytes, drops empty runs, queues the rest.
module nrcd_front
  import nrcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  nrcd_chan_if.sink         code_ch,
  input  logic              pop,
  output run_head_t         head
);

  localparam int QD = 4;
  localparam int PW = $clog2(QD);

  run_ent_t        q_mem [QD];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;
  logic            accept;
  logic            push;
  logic            do_pop;

  // Zero-count bytes produce nothing, so they never enter the queue
  assign code_ch.ready = (fill != (PW+1)'(QD));
  assign accept        = code_ch.valid && code_ch.ready;
  assign push          = accept && (code_ch.data.code_byte[7:4] != 4'd0);
  assign do_pop        = pop && (fill != '0);

  assign head.valid = (fill != '0);
  assign head.ent   = q_mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{count: code_ch.data.code_byte[7:4],
                         color: code_ch.data.code_byte[3:0]};
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= rd_ptr + PW'(1);
      fill <= fill + (PW+1)'(push) - (PW+1)'(do_pop);
    end
  end

endmodule

// File: sv/nrcd_back.sv
// Back end: expands queued runs into pixels with row padding.
module nrcd_back
  import nrcd_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  geom_t         geom,
  input  run_head_t     head,
  output logic          pop,
  nrcd_chan_if.source   pixel_ch
);

  localparam int CW = $clog2(MAX_WIDTH + 4);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_PAD  = 3'b100
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  col, col_next;
  logic [RW-1:0]  row, row_next;
  logic           done, done_next;
  logic [3:0]     cnt, cnt_next;
  logic [3:0]     color, color_next;

  logic [CW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [CW-1:0]  padded;
  logic [CW-1:0]  col_inc;
  logic           row_last;
  logic [RW-1:0]  row_init;
  logic           done_init;

  logic           ovalid;
  pixel_t         opix;
  logic           ready_ok;
  logic           emit;
  pixel_t         pix;

  // Clamp geometry to the supported maximum
  always_comb begin
    if (32'(geom.width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(geom.width);
    if (32'(geom.height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(geom.height);
  end

  assign padded    = (w_eff + CW'(PAD_MASK)) & ~CW'(PAD_MASK);
  assign col_inc   = col + CW'(1);
  assign row_last  = (row == '0);
  assign row_init  = (h_eff == '0) ? '0 : RW'(h_eff - HW'(1));
  assign done_init = (w_eff == '0) || (h_eff == '0);

  assign ready_ok = !ovalid || pixel_ch.ready;

  // Expansion sequencer
  always_comb begin
    state_next = state;
    col_next   = col;
    row_next   = row;
    done_next  = done;
    cnt_next   = cnt;
    color_next = color;
    pop        = 1'b0;
    emit       = 1'b0;
    pix        = '0;
    unique case (state)
      ST_IDLE: begin
        // runs arriving after completion are discarded; hold the queue
        // while a restart is pending so no run is lost to it
        pop = head.valid && !geom.restart;
        if (head.valid && !done) begin
          cnt_next   = head.ent.count;
          color_next = head.ent.color;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ready_ok) begin
          emit             = 1'b1;
          pix.pixel_color  = color;
          pix.pixel_column = 8'(col);
          pix.pixel_row    = 8'(row);
          cnt_next         = cnt - 4'd1;
          if (col_inc >= w_eff) begin
            if (padded != w_eff) begin
              col_next   = w_eff;
              state_next = ST_PAD;
            end else begin
              col_next = '0;
              if (row_last) begin
                done_next        = 1'b1;
                pix.last_of_item = 1'b1;
                pix.image_done   = 1'b1;
                state_next       = ST_IDLE;
              end else begin
                row_next         = row - RW'(1);
                pix.last_of_item = (cnt == 4'd1);
                state_next       = (cnt == 4'd1) ? ST_IDLE : ST_RUN;
              end
            end
          end else begin
            col_next         = col_inc;
            pix.last_of_item = (cnt == 4'd1);
            state_next       = (cnt == 4'd1) ? ST_IDLE : ST_RUN;
          end
        end
      end
      ST_PAD: begin
        if (ready_ok) begin
          emit             = 1'b1;
          pix.pixel_color  = geom.transparent;
          pix.pixel_column = 8'(col);
          pix.pixel_row    = 8'(row);
          pix.is_padding   = 1'b1;
          if (col_inc == padded) begin
            col_next = '0;
            if (row_last) begin
              done_next        = 1'b1;
              pix.last_of_item = 1'b1;
              pix.image_done   = 1'b1;
              state_next       = ST_IDLE;
            end else begin
              row_next         = row - RW'(1);
              pix.last_of_item = (cnt == 4'd0);
              state_next       = (cnt == 4'd0) ? ST_IDLE : ST_RUN;
            end
          end else begin
            col_next = col_inc;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Position and sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b1;
      col   <= '0;
      row   <= '0;
    end else if (geom.restart) begin
      state <= ST_IDLE;
      done  <= done_init;
      col   <= '0;
      row   <= row_init;
    end else begin
      state <= state_next;
      done  <= done_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt   <= cnt_next;
    color <= color_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (ready_ok) begin
      ovalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_ok && emit) opix <= pix;
  end

  assign pixel_ch.valid = ovalid;
  assign pixel_ch.data  = opix;

  // A run being expanded always has pixels left
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt != 4'd0))
    else $error("run state with zero count");

  // Real pixels stay inside the image width
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (col < w_eff))
    else $error("column beyond image width");

  // Completion is set only together with the final pixel
  a_done_tag: assert property (@(posedge clk) disable iff (rst)
    ($rose(done) && !$past(geom.restart) && !$past(rst)) |-> (ovalid && opix.image_done))
    else $error("image completed without final pixel");

endmodule

// File: sv/nibble_rle_cel_decoder_unit.sv
// Top level of the nibble run-length cel decoder: config registers and wiring.
//
// Usage:
//   code_ch carries one code byte per request: bits 7..4 are a run count, 3..0
//   a color. pixel_ch carries one pixel per request with color, column, row, a
//   padding flag, a last-of-byte flag and an end-of-image flag. Both channels
//   use valid/ready; a request moves when both are high.
//   Configuration: cfg_we with cfg_index/cfg_data writes cel_width (0),
//   cel_height (1) or transparent_color (2). A geometry write restarts the image
//   at the top row through the registered restart flag. Write only while idle.
// Flow:
//   A byte passes a 4-entry run queue, then the expander loads it in its idle
//   state and emits one pixel per cycle while pixel_ch does not stall. Zero-count
//   bytes are dropped at one per cycle while the queue has room.
// Reset and stalls:
//   rst is synchronous; registers return to width 16, height 16, color 3 and
//   the image restarts. When pixel_ch stalls the pixel holds in the output
//   register, the expander waits, and the queue keeps taking bytes until full.
module nibble_rle_cel_decoder_unit
  import nrcd_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  nrcd_chan_if.sink             code_ch,
  nrcd_chan_if.source           pixel_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic [8:0]  cel_width;
  logic [8:0]  cel_height;
  logic [3:0]  transparent_color;
  logic        restart;
  geom_t       geom;
  run_head_t   head;
  logic        pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cel_width         <= RESET_CEL_WIDTH;
      cel_height        <= RESET_CEL_HEIGHT;
      transparent_color <= RESET_TRANSPARENT;
      restart           <= 1'b1;
    end else begin
      // geometry writes restart the image
      restart <= cfg_we && ((cfg_index == REG_CEL_WIDTH) ||
                            (cfg_index == REG_CEL_HEIGHT));
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CEL_WIDTH:   cel_width <= cfg_data;
          REG_CEL_HEIGHT:  cel_height <= cfg_data;
          REG_TRANSPARENT: transparent_color <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  assign geom = '{restart: restart, width: cel_width, height: cel_height,
                  transparent: transparent_color};

  nrcd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .code_ch (code_ch),
    .pop     (pop),
    .head    (head)
  );

  nrcd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .head     (head),
    .pop      (pop),
    .pixel_ch (pixel_ch)
  );

endmodule
